// ----- hw/rtl/ffdl_pkg.sv -----
// ----------------------------------------------------------------------------
// ffdl_pkg
// Shared types and constants of the fractional feedback delay line.
// ----------------------------------------------------------------------------
package ffdl_pkg;

  // Fixed field widths of the streaming and configuration interfaces.
  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 23;
  localparam int GAIN_W     = 15;
  localparam int FRAC_BITS  = 8;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Default store depth in samples.
  localparam int DEPTH_DEFAULT = 32768;

  // Largest usable feedback gain, 0.98 in Q0.15.
  localparam logic [GAIN_W-1:0] FB_MAX = 15'd32112;

  // Register index carried by paddr[2].
  localparam logic REG_FEEDBACK_GAIN = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RD1,
    S_DIFF,
    S_MUL,
    S_INTERP,
    S_WRITE
  } ffdl_state_t;

endpackage

// ----- hw/rtl/fractional_feedback_delay_line.sv -----
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line
// Circular delay line with a fractional read tap, linear interpolation and
// saturating feedback into the store.
// ----------------------------------------------------------------------------
//
//  Channel  Kind          Word contents (lowest bit first)
//  -------  ------------  ------------------------------------------------
//  s_*      stream in     sample_in[15:0], delay_q8[38:16], zero pad [39]
//  m_*      stream out    delayed_out[15:0]
//  APB      config        0x0: feedback_gain[14:0] (Q0.15, used up to 0.98)
//
// A word is accepted only while the block is idle; the block is busy after
// acceptance because the two store reads go through the single registered
// read port one after the other, and one shared 17x16 multiplier computes
// first the blend product and then the feedback product. The result is held
// in an output register, so a waiting result does not stop the next word
// from being accepted; only the final store write waits for the output
// register to drain.
// After reset the store is cleared one entry per cycle over all DEPTH entries,
// and during that pass no word is accepted; register writes are taken anyway.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line #(
  parameter int DEPTH = ffdl_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream: sample_in [15:0], delay_q8 [38:16], zero [39].
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ffdl_pkg::S_TDATA_W-1:0]  s_tdata,
  // Output stream: delayed_out [15:0].
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ffdl_pkg::M_TDATA_W-1:0]  m_tdata,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffdl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ffdl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ffdl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import ffdl_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  // The clamped delay needs room for (DEPTH-2) whole samples plus the fraction.
  localparam int DQ_W  = (IDX_W + FRAC_BITS > DELAY_W) ? IDX_W + FRAC_BITS : DELAY_W;
  localparam logic [DQ_W-1:0]  DQ_MIN    = DQ_W'(2 ** FRAC_BITS);
  localparam logic [DQ_W-1:0]  DQ_MAX    = DQ_W'((DEPTH - 2) * (2 ** FRAC_BITS));
  localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] D0_MAX    = IDX_W'(DEPTH - 2);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic signed [SAMPLE_W+1:0] SAT_HI = (SAMPLE_W + 2)'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SAMPLE_W+1:0] SAT_LO = -SAT_HI - (SAMPLE_W + 2)'(1);

  // Control state.
  ffdl_state_t       state;
  ffdl_state_t       state_next;
  logic              mul_phase;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  clr_addr;
  logic [GAIN_W-1:0] gain;

  // Datapath registers.
  logic signed [SAMPLE_W-1:0] sample_x;
  logic [IDX_W-1:0]           d0;
  logic [FRAC_BITS-1:0]       frac;
  logic [IDX_W-1:0]           rd0_addr;
  logic signed [SAMPLE_W-1:0] y0;
  logic signed [SAMPLE_W-1:0] y_val;
  logic signed [SAMPLE_W:0]   op_a;
  logic signed [SAMPLE_W-1:0] op_b;
  logic signed [2*SAMPLE_W:0] prod;

  // Combinational datapath.
  logic                       s_accept;
  logic                       out_free;
  logic                       cfg_wr;
  logic [DQ_W-1:0]            dq_in;
  logic [DQ_W-1:0]            dq_clamped;
  logic [IDX_W:0]             r0_diff;
  logic [IDX_W-1:0]           r0_addr;
  logic [IDX_W-1:0]           r1_addr;
  logic signed [SAMPLE_W:0]   blend_diff;
  logic signed [SAMPLE_W-1:0] y_interp;
  logic [GAIN_W-1:0]          gain_eff;
  logic signed [SAMPLE_W+1:0] fb_sum;
  logic signed [SAMPLE_W-1:0] fb_sat;

  // Store port.
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;

  ffdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration port. Only the gain register exists; the other register
  // index (paddr[2] set) reads as zero and ignores writes. The raw value is
  // stored and read back, the clamp to 0.98 is applied where the gain is used.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_FEEDBACK_GAIN) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_FEEDBACK_GAIN) begin
      prdata = {{(CFG_DATA_W - GAIN_W){1'b0}}, gain};
    end
  end

  // --------------------------------------------------------------------------
  // Address and arithmetic helpers.
  // --------------------------------------------------------------------------
  assign s_accept = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // Clamp the delay to one sample below and DEPTH-2 samples above.
  assign dq_in = DQ_W'(s_tdata[SAMPLE_W +: DELAY_W]);
  always_comb begin
    if (dq_in < DQ_MIN) begin
      dq_clamped = DQ_MIN;
    end else if (dq_in > DQ_MAX) begin
      dq_clamped = DQ_MAX;
    end else begin
      dq_clamped = dq_in;
    end
  end

  // Tap d0 behind the write position, wrapping around the circular store.
  // Since d0 is at least one and below DEPTH, one conditional add suffices.
  assign r0_diff = {1'b0, wr_idx} - {1'b0, d0};
  assign r0_addr = r0_diff[IDX_W] ? IDX_W'(r0_diff + DEPTH_X) : r0_diff[IDX_W-1:0];
  assign r1_addr = (rd0_addr == '0) ? LAST_IDX : rd0_addr - IDX_ONE;

  // y1 - y0, with y1 arriving from the store in this cycle.
  assign blend_diff = $signed({mem_rdata[SAMPLE_W-1], mem_rdata}) - $signed({y0[SAMPLE_W-1], y0});

  // y0 + floor(frac * (y1 - y0) / 256); the shifted product fits 17 bits and
  // the sum always lies between y0 and y1.
  assign y_interp = SAMPLE_W'($signed({y0[SAMPLE_W-1], y0}) + $signed(prod[FRAC_BITS +: SAMPLE_W + 1]));

  assign gain_eff = (gain > FB_MAX) ? FB_MAX : gain;

  // x + floor(y * g / 32768), saturated to the sample range.
  assign fb_sum = $signed({{2{sample_x[SAMPLE_W-1]}}, sample_x})
                + $signed({prod[GAIN_W + SAMPLE_W], prod[GAIN_W +: SAMPLE_W + 1]});
  always_comb begin
    if (fb_sum > SAT_HI) begin
      fb_sat = SAMPLE_W'(SAT_HI);
    end else if (fb_sum < SAT_LO) begin
      fb_sat = SAMPLE_W'(SAT_LO);
    end else begin
      fb_sat = fb_sum[SAMPLE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wr_idx;
    mem_wdata  = fb_sat;
    mem_raddr  = rd0_addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        mem_raddr  = r0_addr;
        state_next = S_RD1;
      end
      S_RD1: begin
        mem_raddr  = r1_addr;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = mul_phase ? S_WRITE : S_INTERP;
      end
      S_INTERP: begin
        state_next = S_MUL;
      end
      S_WRITE: begin
        if (out_free) begin
          mem_we     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers: clear counter, write pointer, multiplier phase and
  // output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      wr_idx    <= '0;
      mul_phase <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_ONE;
      end
      if (state == S_DIFF) begin
        mul_phase <= 1'b0;
      end else if (state == S_INTERP) begin
        mul_phase <= 1'b1;
      end
      if (state == S_WRITE && out_free) begin
        wr_idx   <= (wr_idx == LAST_IDX) ? '0 : wr_idx + IDX_ONE;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers; the multiplier is shared by the blend and the
  // feedback product.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      sample_x <= s_tdata[SAMPLE_W-1:0];
      d0       <= dq_clamped[FRAC_BITS +: IDX_W];
      frac     <= dq_clamped[FRAC_BITS-1:0];
    end
    if (state == S_ADDR) begin
      rd0_addr <= r0_addr;
    end
    if (state == S_RD1) begin
      y0 <= mem_rdata;
    end
    if (state == S_DIFF) begin
      op_a <= blend_diff;
      op_b <= $signed({{(SAMPLE_W - FRAC_BITS){1'b0}}, frac});
    end
    if (state == S_INTERP) begin
      y_val <= y_interp;
      op_a  <= $signed({y_interp[SAMPLE_W-1], y_interp});
      op_b  <= $signed({{(SAMPLE_W - GAIN_W){1'b0}}, gain_eff});
    end
    if (state == S_MUL) begin
      prod <= op_a * op_b;
    end
    if (state == S_WRITE && out_free) begin
      m_tdata <= y_val;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> state == S_ADDR)
    else $error("accepted word did not start the read sequence");

  a_wr_idx_range: assert property (@(posedge clk) disable iff (rst)
    wr_idx <= LAST_IDX)
    else $error("write pointer beyond the store");

  a_we_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_WRITE))
    else $error("store written outside clear or write-back");

  a_d0_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ADDR |-> (d0 >= IDX_ONE && d0 <= D0_MAX))
    else $error("clamped delay out of range");

  a_tap_not_head: assert property (@(posedge clk) disable iff (rst)
    state == S_RD1 |-> rd0_addr != wr_idx)
    else $error("read tap collides with the write position");

endmodule

// ----- hw/rtl/ffdl_ram.sv -----
// ----------------------------------------------------------------------------
// ffdl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/fractional_feedback_delay_line_tb.sv -----
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line_tb
// Self-checking bench for the fractional feedback delay line. A short table
// of hand-picked words (clamps, saturation, rounding, the gain limit) is
// followed by random phases at several feedback gains. A predictor keeps
// its own copy of the delay store, write position and gain. Every word on
// the output stream is compared against the oldest predicted tap value.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffdl_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // Legal delay range in Q15.8 units: one sample up to DEPTH-2 samples.
  localparam int DLY_MIN = 1 << FRAC_BITS;
  localparam int DLY_MAX = (DEPTH - 2) << FRAC_BITS;

  // Signed sample range.
  localparam int SMP_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SMP_MIN = -(1 << (SAMPLE_W - 1));

  // Byte addresses on the configuration port. The spare address selects a
  // register index that does not exist, so writes to it must be dropped.
  localparam logic [CFG_ADDR_W-1:0] ADDR_GAIN  = {REG_FEEDBACK_GAIN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = {~REG_FEEDBACK_GAIN, 2'b00};

  // The store is cleared entry by entry after reset, so the idle limit
  // must cover that pass several times over.
  localparam int WATCHDOG_LIMIT = 5 * DEPTH;

  // The store write and the output register load happen together, so no
  // write is pending once the last tap is out; this many cycles pass as a
  // margin before the gain is changed and at the very end.
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_WORDS    = 200;
  localparam int NUM_PHASES     = 6;

  typedef struct packed {
    bit                  known;  // want holds a hand-worked value
    logic [SAMPLE_W-1:0] smp;
    logic [DELAY_W-1:0]  dly;
    logic [SAMPLE_W-1:0] want;
  } tap_row_t;

  // Hand-picked words, sent right after reset with the gain at 32767.
  // The first rows are worked out by hand; the gain is used as 0.98.
  localparam int NUM_ROWS = 17;
  localparam tap_row_t DIRECTED [NUM_ROWS] = '{
    // Delay of zero is raised to one sample; the store is still empty.
    '{1'b1, 16'h7FFF, 23'h000000, 16'h0000},
    // One sample back reads the full-scale word just written.
    '{1'b1, 16'h8000, 23'h000100, 16'h7FFF},
    // Largest delay code is clamped to DEPTH-2 and reads an empty entry.
    '{1'b1, 16'h0000, 23'h7FFFFF, 16'h0000},
    // Half-way blend of 0 and -657 rounds down to -329; the feedback sum
    // then saturates at the negative limit.
    '{1'b1, 16'h8000, 23'h000180, 16'hFEB7},
    // Reads the saturated negative entry.
    '{1'b1, 16'h7FFF, 23'h000100, 16'h8000},
    // Reads the first entry again; the feedback sum saturates high.
    '{1'b1, 16'h7FFF, 23'h000500, 16'h7FFF},
    // The rest are left to the predictor.
    '{1'b0, 16'h03E8, 23'h0000FF, 16'h0000},  // just below one sample
    '{1'b0, 16'hFC18, 23'h0001FF, 16'h0000},  // largest fraction
    '{1'b0, 16'h3039, 23'h7FFE00, 16'h0000},  // exactly the upper limit
    '{1'b0, 16'hCFC7, 23'h7FFE01, 16'h0000},  // just above the upper limit
    '{1'b0, 16'h0000, 23'h400000, 16'h0000},  // top delay bit alone
    '{1'b0, 16'h0001, 23'h3FFFFF, 16'h0000},
    '{1'b0, 16'hFFFF, 23'h000201, 16'h0000},
    '{1'b0, 16'h4000, 23'h0003C8, 16'h0000},
    '{1'b0, 16'hC000, 23'h0002FF, 16'h0000},
    '{1'b0, 16'h7FFF, 23'h000100, 16'h0000},
    '{1'b0, 16'h8000, 23'h000101, 16'h0000}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // Fields from bit 0 up: sample_in[15:0], delay_q8[38:16], zero pad [39].
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // Fields from bit 0 up: delayed_out[15:0].
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fractional_feedback_delay_line #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state: the delay store, the next write position and the gain
  // as last written through the configuration port.
  logic signed [SAMPLE_W-1:0] echo_mem [DEPTH];
  int                         wr_pos;
  logic [GAIN_W-1:0]          fb_gain;

  // Tap values still owed by the block, oldest first.
  logic [SAMPLE_W-1:0]        tap_q [$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int gap_pct      = 0;  // chance in percent that the sender pauses
  int stall_pct    = 0;  // chance in percent that the receiver stalls

  // Works out the tap for one accepted word and applies the feedback write.
  // All arithmetic is done in int; an arithmetic shift of a signed int
  // rounds toward minus infinity, which is what the block does.
  function automatic logic [SAMPLE_W-1:0] tap_and_feed(
      input logic signed [SAMPLE_W-1:0] x, input logic [DELAY_W-1:0] dq);
    int dqc, d0, fr, r0, r1, y0, y1, y, g, acc;
    dqc = dq;
    if (dqc < DLY_MIN) dqc = DLY_MIN;
    if (dqc > DLY_MAX) dqc = DLY_MAX;
    d0 = dqc >> FRAC_BITS;
    fr = dqc % DLY_MIN;
    r0 = (wr_pos + DEPTH - d0) % DEPTH;
    r1 = (r0 + DEPTH - 1) % DEPTH;
    y0 = echo_mem[r0];
    y1 = echo_mem[r1];
    y  = y0 + ((fr * (y1 - y0)) >>> FRAC_BITS);
    g  = (fb_gain > FB_MAX) ? FB_MAX : fb_gain;
    acc = x + ((y * g) >>> (GAIN_W));
    if (acc > SMP_MAX) acc = SMP_MAX;
    if (acc < SMP_MIN) acc = SMP_MIN;
    echo_mem[wr_pos] = acc[SAMPLE_W-1:0];
    wr_pos = (wr_pos + 1) % DEPTH;
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Drives one input word and holds it until the block takes it. The tap is
  // predicted at the accepting edge; a hand-worked value, where given, is
  // expected instead. Afterwards the sender may pause for a short burst.
  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic [DELAY_W-1:0] dly,
                           input bit known, input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] tap;
    s_tdata  <= {1'b0, dly, smp};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tap = tap_and_feed(smp, dly);
    tap_q.push_back(known ? want : tap);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stops the sender and waits until every predicted tap has come back.
  // It waits on the clock before it checks the queue, so the valid line settles low first.
  task automatic drain_taps();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tap_q.size() != 0);
  endtask

  // Register access with a setup and an access phase. The transfer happens at
  // the edge where psel, penable and pready are all high; read data is sampled
  // at that edge. psel and penable are then dropped before the task returns.
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the gain, mirrors it in the predictor and reads it back.
  task automatic set_gain(input logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b1, ADDR_GAIN, CFG_DATA_W'(gain), rd);
    fb_gain = gain;
    cfg_access(1'b0, ADDR_GAIN, '0, rd);
    if (rd !== CFG_DATA_W'(fb_gain)) report_mismatch("gain readback", rd, fb_gain);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Most delays are short so that the taps land on entries already written
  // and the feedback path stays busy; the rest cover the whole code range
  // and both clamps.
  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return DELAY_W'($urandom_range(0, (1 << DELAY_W) - 1));
      1:       return DELAY_W'($urandom_range(0, DLY_MIN + 64));
      2:       return DELAY_W'($urandom_range(DLY_MAX - 64, (1 << DELAY_W) - 1));
      3:       return DELAY_W'($urandom_range(DLY_MIN, 4096 << FRAC_BITS));
      default: return DELAY_W'($urandom_range(DLY_MIN, (48 << FRAC_BITS) + 255));
    endcase
  endfunction

  // Output word checker. Values on the output stream are sampled at the
  // edge, before the block's own updates land.
  always @(posedge clk) begin : tap_check
    logic [SAMPLE_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (tap_q.size() == 0) begin
        report_mismatch("unexpected output word", $signed(m_tdata), 0);
      end else begin
        want = tap_q.pop_front();
        if (m_tdata !== want)
          report_mismatch("delayed_out", $signed(m_tdata), $signed(want));
      end
    end
  end

  // Ends the run when no word moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: ready most of the time, with stall bursts set off at random by stall_pct.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [GAIN_W-1:0]     phase_gain [NUM_PHASES];
    logic [CFG_DATA_W-1:0] rd;

    for (int i = 0; i < DEPTH; i++) echo_mem[i] = '0;
    wr_pos  = 0;
    fb_gain = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The gain is taken even while the store is being cleared. The largest
    // code shows the clamp to 0.98 in the hand-worked rows.
    set_gain(15'h7FFF);

    gap_pct   = 30;
    stall_pct = 30;
    for (int i = 0; i < NUM_ROWS; i++)
      send_word(DIRECTED[i].smp, DIRECTED[i].dly, DIRECTED[i].known, DIRECTED[i].want);

    // Random phases. The gain steps through zero, one half, the smallest
    // nonzero value, the limit, one above it and a random code. The last
    // phase runs with no pauses on either stream.
    phase_gain = '{15'd0, 15'd16384, 15'd1, FB_MAX, FB_MAX + 15'd1,
                   GAIN_W'($urandom)};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_taps();
      // The store write lands with the output register load, so it is done by now.
      repeat (SETTLE_CYCLES) @(posedge clk);
      set_gain(phase_gain[ph]);
      // A write to an index that does not exist must leave the gain alone;
      // the words of this phase are checked with the gain set above.
      if (ph == 2) cfg_access(1'b1, ADDR_SPARE, $urandom, rd);

      if (ph == NUM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 40);
        stall_pct = $urandom_range(0, 40);
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Partway through one phase the sender holds off until the block has
        // returned every outstanding word.
        if (ph == 1 && n == PHASE_WORDS / 2) drain_taps();
        send_word(pick_sample(), pick_delay(), 1'b0, '0);
      end
    end

    drain_taps();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- fractional_feedback_delay_line.f -----
hw/rtl/ffdl_pkg.sv
hw/rtl/ffdl_ram.sv
hw/rtl/fractional_feedback_delay_line.sv
tb/fractional_feedback_delay_line_tb.sv
